>>> rtl/tgsc_pkg.sv
`default_nettype none
package tgsc_pkg;

	localparam int DEF_MAX_COLS   = 64;
	localparam int DEF_MAX_ROWS   = 64;
	localparam int DEF_COORD_BITS = 24;

	localparam int TYPE_W     = 2;
	localparam int TILE_IDX_W = 6;
	localparam int SHIFT_W    = 5;
	localparam int COUNT_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [TYPE_W-1:0] REQ_WRITE  = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_VSWEEP = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_HSWEEP = 2'd2;
	localparam logic [TYPE_W-1:0] REQ_NONE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_TILE_SHIFT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 2'd2;

	localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd7;
	localparam logic [COUNT_W-1:0] COLS_RST  = 7'd64;
	localparam logic [COUNT_W-1:0] ROWS_RST  = 7'd64;

	typedef struct packed {
		logic clear;
		logic load;
		logic tile_wr;
		logic setup;
		logic issue;
		logic out_load;
	} tgsc_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_empty;
		logic scan_last;
		logic pipe_busy;
	} tgsc_status_t;

	function automatic int in_dw(int cb);
		return ((4 * cb + 2 * TILE_IDX_W + 1 + 7) / 8) * 8;
	endfunction

	function automatic int out_dw(int cb);
		return ((cb + 2 + 7) / 8) * 8;
	endfunction

endpackage
`default_nettype wire

>>> rtl/tile_grid_sweep_collision_unit.sv
`default_nettype none
// Channel   Dir  Handshake           Content
// s_*       in   s_tvalid/s_tready   request: tuser type, tdata tile or sweep fields
// m_*       out  m_tvalid/m_tready   one result per sweep request
// cfg_*     in   cfg_valid/cfg_ready register index and write data
//
// After reset the tile map is cleared one tile per cycle, all MAX_COLS*MAX_ROWS
// tiles (4096 at default size), with s_tready low; config writes are taken.
// A tile write leaves the unit ready. A sweep reads one tile per cycle through a three
// stage read/edge/update pipe, scanning the cross cells times the sweep cells; the
// result is loaded once the pipe has drained.
// A finished result waits in the output register; a new request is taken
// meanwhile, and the next result holds until that register frees up.
module tile_grid_sweep_collision_unit #(
	parameter int MAX_COLS   = tgsc_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS   = tgsc_pkg::DEF_MAX_ROWS,
	parameter int COORD_BITS = tgsc_pkg::DEF_COORD_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// pos, span_lo, span_hi, sweep_dist, tile_col, tile_row, tile_solid
	input  wire logic [tgsc_pkg::in_dw(COORD_BITS)-1:0] s_tdata,
	// req_type
	input  wire logic [tgsc_pkg::TYPE_W-1:0]            s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// allowed_dist, blocked
	output logic [tgsc_pkg::out_dw(COORD_BITS)-1:0]     m_tdata,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [tgsc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [tgsc_pkg::CFG_DATA_W-1:0]        cfg_data
);

	import tgsc_pkg::*;

	tgsc_cmd_t    cmd;
	tgsc_status_t status;

	assign cfg_ready = 1'b1;

	tgsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	tgsc_dp #(
		.MAX_COLS   (MAX_COLS),
		.MAX_ROWS   (MAX_ROWS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.in_type   (s_tuser),
		.cmd       (cmd),
		.status    (status),
		.out_data  (m_tdata)
	);

`ifndef SYNTHESIS
	a_ready_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !status.pipe_busy)
		else $error("request taken while scan pipe busy");

	a_write_stays_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == REQ_WRITE || s_tuser == REQ_NONE))
		|=> s_tready)
		else $error("tile write left the unit busy");

	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == REQ_VSWEEP || s_tuser == REQ_HSWEEP))
		|=> !s_tready)
		else $error("sweep request did not start a scan");

	a_load_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !status.pipe_busy)
		else $error("result loaded before scan pipe drained");
`endif

endmodule
`default_nettype wire

>>> rtl/tgsc_ram.sv
`default_nettype none
module tgsc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/tgsc_ctrl.sv
`default_nettype none
module tgsc_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic [tgsc_pkg::TYPE_W-1:0]   s_tuser,
	output logic                               s_tready,
	input  wire logic                          m_tready,
	output logic                               m_tvalid,
	input  wire tgsc_pkg::tgsc_status_t        status,
	output tgsc_pkg::tgsc_cmd_t                cmd
);

	import tgsc_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					case (s_tuser) inside
						REQ_WRITE:              cmd.tile_wr = 1'b1;
						REQ_VSWEEP, REQ_HSWEEP: state_d = ST_SETUP;
						default: ;
					endcase
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_empty) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.issue = 1'b1;
					if (status.scan_last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy && (!out_valid_q || m_tready)) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/tgsc_dp.sv
`default_nettype none
module tgsc_dp #(
	parameter int MAX_COLS   = tgsc_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS   = tgsc_pkg::DEF_MAX_ROWS,
	parameter int COORD_BITS = tgsc_pkg::DEF_COORD_BITS
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      cfg_valid,
	input  wire logic [tgsc_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  wire logic [tgsc_pkg::CFG_DATA_W-1:0]           cfg_data,
	input  wire logic [tgsc_pkg::in_dw(COORD_BITS)-1:0]    in_data,
	input  wire logic [tgsc_pkg::TYPE_W-1:0]               in_type,
	input  wire tgsc_pkg::tgsc_cmd_t                       cmd,
	output tgsc_pkg::tgsc_status_t                         status,
	output logic [tgsc_pkg::out_dw(COORD_BITS)-1:0]        out_data
);

	import tgsc_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int MAXN  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int CELLW = $clog2(MAXN);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SHW   = CELLW + 1 + (2 ** SHIFT_W) - 1;
	localparam int EW    = SHW + 2;
	localparam int CMPW  = (CB > CELLW) ? CB : CELLW;
	localparam int CNTW  = (COUNT_W > CELLW + 1) ? COUNT_W : CELLW + 1;
	localparam int OUT_DW = out_dw(COORD_BITS);

	// config
	logic [SHIFT_W-1:0] shift_q;
	logic [COUNT_W-1:0] cols_q;
	logic [COUNT_W-1:0] rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SHIFT_RST;
			cols_q  <= COLS_RST;
			rows_q  <= ROWS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TILE_SHIFT: shift_q <= cfg_data[SHIFT_W-1:0];
				REG_COLS:       cols_q  <= cfg_data[COUNT_W-1:0];
				REG_ROWS:       rows_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// request fields
	logic signed [CB-1:0]   f_pos;
	logic signed [CB-1:0]   f_lo;
	logic signed [CB-1:0]   f_hi;
	logic signed [CB-1:0]   f_dist;
	logic [TILE_IDX_W-1:0]  f_col;
	logic [TILE_IDX_W-1:0]  f_row;
	logic                   f_solid;

	assign f_pos   = in_data[CB-1:0];
	assign f_lo    = in_data[2*CB-1:CB];
	assign f_hi    = in_data[3*CB-1:2*CB];
	assign f_dist  = in_data[4*CB-1:3*CB];
	assign f_col   = in_data[4*CB +: TILE_IDX_W];
	assign f_row   = in_data[4*CB+TILE_IDX_W +: TILE_IDX_W];
	assign f_solid = in_data[4*CB+2*TILE_IDX_W];

	logic signed [CB-1:0] p_q;
	logic signed [CB-1:0] lo_q;
	logic signed [CB-1:0] hi_q;
	logic signed [CB-1:0] d_q;
	logic                 vert_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q    <= f_pos;
			lo_q   <= f_lo;
			hi_q   <= f_hi;
			d_q    <= f_dist;
			vert_q <= (in_type == REQ_VSWEEP);
		end
	end

	// grid limits
	logic [CNTW-1:0]  ncols;
	logic [CNTW-1:0]  nrows;
	logic [CELLW-1:0] lim_c;
	logic [CELLW-1:0] lim_r;
	logic [CELLW-1:0] lim_sweep;
	logic [CELLW-1:0] lim_cross;

	always_comb begin
		ncols = CNTW'(cols_q);
		nrows = CNTW'(rows_q);
		if (ncols == '0) begin
			ncols = CNTW'(1);
		end else if (ncols > CNTW'(MAX_COLS)) begin
			ncols = CNTW'(MAX_COLS);
		end
		if (nrows == '0) begin
			nrows = CNTW'(1);
		end else if (nrows > CNTW'(MAX_ROWS)) begin
			nrows = CNTW'(MAX_ROWS);
		end
		lim_c     = CELLW'(ncols - CNTW'(1));
		lim_r     = CELLW'(nrows - CNTW'(1));
		lim_sweep = vert_q ? lim_r : lim_c;
		lim_cross = vert_q ? lim_c : lim_r;
	end

	function automatic logic [CELLW-1:0] cell_of(logic signed [CB:0] v,
			logic [SHIFT_W-1:0] sh, logic [CELLW-1:0] lim);
		logic [CMPW-1:0] c;
		logic [CMPW-1:0] l;
		c = CMPW'(v[CB-1:0] >> sh);
		l = CMPW'(lim);
		if (v[CB]) begin
			return '0;
		end else if (c > l) begin
			return lim;
		end
		return c[CELLW-1:0];
	endfunction

	logic signed [CB:0]   target;
	logic [CELLW-1:0]     a_c;
	logic [CELLW-1:0]     b_c;
	logic [CELLW-1:0]     cur_c;
	logic [CELLW-1:0]     far_c;
	logic                 down_c;

	always_comb begin
		target = {p_q[CB-1], p_q} + {d_q[CB-1], d_q};
		a_c    = cell_of({lo_q[CB-1], lo_q}, shift_q, lim_cross);
		b_c    = cell_of({hi_q[CB-1], hi_q}, shift_q, lim_cross);
		cur_c  = cell_of({p_q[CB-1], p_q}, shift_q, lim_sweep);
		far_c  = cell_of(target, shift_q, lim_sweep);
		down_c = d_q[CB-1] || (d_q == '0);
	end

	// scan counters
	logic [CELLW-1:0] i_q;
	logic [CELLW-1:0] b_q;
	logic [CELLW-1:0] j_q;
	logic [CELLW-1:0] jst_q;
	logic [CELLW-1:0] cur_q;
	logic [CELLW-1:0] far_q;
	logic             down_q;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			i_q    <= a_c;
			b_q    <= b_c;
			cur_q  <= cur_c;
			far_q  <= far_c;
			down_q <= down_c;
			if (down_c) begin
				jst_q <= cur_c - 1'b1;
				j_q   <= cur_c - 1'b1;
			end else begin
				jst_q <= cur_c + 1'b1;
				j_q   <= cur_c + 1'b1;
			end
		end else if (cmd.issue) begin
			if (j_q == far_q) begin
				j_q <= jst_q;
				i_q <= i_q + 1'b1;
			end else if (down_q) begin
				j_q <= j_q - 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	// tile store
	logic [AW-1:0] clr_q;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic          ram_rdata;
	logic [AW-1:0] wr_addr;
	logic          wr_ok;
	logic [CELLW-1:0] rd_row;
	logic [CELLW-1:0] rd_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		wr_ok     = (int'(f_col) < MAX_COLS) && (int'(f_row) < MAX_ROWS);
		wr_addr   = AW'(int'(f_row) * MAX_COLS + int'(f_col));
		ram_we    = cmd.clear || (cmd.tile_wr && wr_ok);
		ram_waddr = cmd.clear ? clr_q : wr_addr;
		ram_wdata = cmd.clear ? 1'b0 : f_solid;
		rd_row    = vert_q ? j_q : i_q;
		rd_col    = vert_q ? i_q : j_q;
		ram_raddr = AW'(int'(rd_row) * MAX_COLS + int'(rd_col));
	end

	tgsc_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// hit pipeline: read, edge, update
	logic                 v_s1;
	logic                 hit_s2;
	logic [CELLW-1:0]     j_s1;
	logic signed [EW-1:0] edge_s2;
	logic [CELLW:0]       jp;
	logic [SHW-1:0]       bound;
	logic signed [EW-1:0] edge_c;

	always_comb begin
		jp     = {1'b0, j_s1} + (down_q ? (CELLW+1)'(1) : '0);
		bound  = SHW'(jp) << shift_q;
		edge_c = $signed({2'b00, bound}) - EW'(p_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			hit_s2 <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			hit_s2 <= v_s1 && ram_rdata;
		end
	end

	logic signed [CB-1:0] allowed_q;
	logic signed [CB:0]   out_dist_q;
	logic                 out_blk_q;

	always_ff @(posedge clk) begin
		j_s1    <= j_q;
		edge_s2 <= edge_c;
		if (cmd.setup) begin
			allowed_q <= d_q;
		end else if (hit_s2) begin
			if (down_q ? (edge_s2 > EW'(allowed_q)) : (edge_s2 < EW'(allowed_q))) begin
				allowed_q <= edge_s2[CB-1:0];
			end
		end
		if (cmd.out_load) begin
			out_dist_q <= {allowed_q[CB-1], allowed_q};
			out_blk_q  <= (allowed_q != d_q);
		end
	end

	assign out_data = OUT_DW'({out_blk_q, out_dist_q});

	always_comb begin
		status.clr_last   = (clr_q == AW'(DEPTH - 1));
		status.scan_empty = (i_q > b_q) || (down_q ? (far_q >= cur_q) : (far_q <= cur_q));
		status.scan_last  = (j_q == far_q) && (i_q == b_q);
		status.pipe_busy  = v_s1 || hit_s2;
	end

endmodule
`default_nettype wire
